[rtl/core/atrsp_pkg.sv]
package atrsp_pkg;

  localparam int POS_OUT_W    = 11;
  localparam int CODE_W       = 4;
  localparam int KW_COUNT     = 12;
  localparam int KW_MAX       = 11;

  localparam logic [CODE_W-1:0] CODE_INVALID = 4'd12;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_T_UP  = 8'h54;
  localparam logic [7:0] CH_T_LO  = 8'h74;

  typedef logic [7:0] kw_text_t [KW_MAX];

  // Status keywords, left aligned, zero padded; index is the status code.
  localparam logic [7:0] KW_CHARS [KW_COUNT][KW_MAX] = '{
    '{"O", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{">", " ", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"C", "O", "N", "N", "E", "C", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "E", "N", "D", " ", "O", "K", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "E", "N", "D", " ", "F", "A", "I", "L", 8'h00, 8'h00},
    '{"R", "I", "N", "G", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"N", "O", " ", "C", "A", "R", "R", "I", "E", "R", 8'h00},
    '{"E", "R", "R", "O", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"N", "O", " ", "D", "I", "A", "L", "T", "O", "N", "E"},
    '{"B", "U", "S", "Y", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"N", "O", " ", "A", "N", "S", "W", "E", "R", 8'h00, 8'h00},
    '{"P", "R", "O", "C", "E", "E", "D", "I", "N", "G", 8'h00}
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd2, 4'd2, 4'd7, 4'd7, 4'd9, 4'd4, 4'd10, 4'd5, 4'd11, 4'd4, 4'd9, 4'd10
  };

  typedef struct packed {
    logic                 cmd_present;
    logic [POS_OUT_W-1:0] cmd_begin;
    logic [POS_OUT_W-1:0] cmd_finish;
    logic                 unsol_present;
    logic [POS_OUT_W-1:0] unsol_begin;
    logic [POS_OUT_W-1:0] unsol_finish;
    logic [CODE_W-1:0]    status_code;
    logic                 index_overflow;
  } result_t;

endpackage

[rtl/core/atrsp_keyword_match.sv]
module atrsp_keyword_match import atrsp_pkg::*; #(
  parameter int POS_W        = 11,
  parameter int STATUS_CHARS = 16
) (
  input  kw_text_t          text,
  input  logic [POS_W-1:0]  start_pos,
  input  logic [POS_W-1:0]  end_pos,
  output logic [CODE_W-1:0] code
);

  logic [POS_W-1:0]    len;
  logic                len_ok;
  logic [KW_COUNT-1:0] hit;

  assign len    = end_pos - start_pos;
  assign len_ok = (end_pos > start_pos) && (32'(len) < 32'(STATUS_CHARS));

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      hit[k] = len_ok && (len == POS_W'(KW_LEN[k]));
      for (int j = 0; j < KW_MAX; j++) begin
        if ((j < int'(KW_LEN[k])) && (text[j] != KW_CHARS[k][j])) begin
          hit[k] = 1'b0;
        end
      end
    end
  end

  // lowest keyword wins
  always_comb begin
    code = CODE_INVALID;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (hit[k]) begin
        code = CODE_W'(k);
      end
    end
  end

endmodule

[rtl/core/atrsp_parser.sv]
module atrsp_parser import atrsp_pkg::*; #(
  parameter int MAX_LEN      = 1024,
  parameter int STATUS_CHARS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step_en,
  input  logic [7:0] char_in,
  output logic       res_valid,
  output result_t    res
);

  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam int TXT_W = $clog2(STATUS_CHARS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_LEN - 1);

  localparam logic [3:0] PH_START        = 4'd0;
  localparam logic [3:0] PH_ENTER_AT     = 4'd1;
  localparam logic [3:0] PH_AT           = 4'd2;
  localparam logic [3:0] PH_ENTER_STATUS = 4'd3;
  localparam logic [3:0] PH_STATUS       = 4'd4;
  localparam logic [3:0] PH_EXIT_STATUS  = 4'd5;
  localparam logic [3:0] PH_USER         = 4'd6;
  localparam logic [3:0] PH_ENTER_SEND   = 4'd7;
  localparam logic [3:0] PH_SEND         = 4'd8;
  localparam logic [3:0] PH_EXIT_SEND    = 4'd9;
  localparam logic [3:0] PH_ENTER_URC    = 4'd10;
  localparam logic [3:0] PH_URC          = 4'd11;
  localparam logic [3:0] PH_EXIT_URC     = 4'd12;

  logic [3:0]       phase, phase_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic             overflow_seen, overflow_seen_next;
  logic [POS_W-1:0] cmd_start_pos, cmd_start_pos_next;
  logic [POS_W-1:0] cmd_end_pos, cmd_end_pos_next;
  logic [POS_W-1:0] status_start_pos, status_start_pos_next;
  logic [POS_W-1:0] status_end_pos, status_end_pos_next;
  logic [POS_W-1:0] unsol_start_pos, unsol_start_pos_next;
  logic [POS_W-1:0] unsol_end_pos, unsol_end_pos_next;
  logic [7:0]       status_text [STATUS_CHARS];

  logic [POS_W-1:0]  cur_pos, cur_pos_inc, prev_pos, cap_off, lookup_end, cmd_end_fin;
  logic              cap_ok, text_we, msg_end, in_status, status_ok;
  logic [TXT_W-1:0]  text_addr;
  logic [CODE_W-1:0] status_code;
  kw_text_t          kw_text;

  assign cur_pos     = POS_W'(byte_index);
  assign cur_pos_inc = cur_pos + POS_W'(1);
  assign prev_pos    = (byte_index != '0) ? cur_pos - POS_W'(1) : '0;
  assign msg_end     = (char_in == CH_NUL);
  assign in_status   = (phase == PH_STATUS);

  assign cap_off   = cur_pos - status_start_pos;
  assign cap_ok    = (cur_pos >= status_start_pos) && (32'(cap_off) < 32'(STATUS_CHARS));
  assign text_addr = cap_off[TXT_W-1:0];

  // the closing zero word ends an open status line at the current index
  assign lookup_end  = (msg_end && in_status) ? cur_pos : status_end_pos;
  assign cmd_end_fin = (msg_end && in_status) ? cur_pos : cmd_end_pos;

  always_comb begin
    for (int j = 0; j < KW_MAX; j++) begin
      kw_text[j] = status_text[j];
    end
  end

  atrsp_keyword_match #(
    .POS_W        (POS_W),
    .STATUS_CHARS (STATUS_CHARS)
  ) u_match (
    .text      (kw_text),
    .start_pos (status_start_pos),
    .end_pos   (lookup_end),
    .code      (status_code)
  );

  assign status_ok = (status_code != CODE_INVALID);

  always_comb begin
    phase_next            = phase;
    byte_index_next       = byte_index;
    overflow_seen_next    = overflow_seen;
    cmd_start_pos_next    = cmd_start_pos;
    cmd_end_pos_next      = cmd_end_pos;
    status_start_pos_next = status_start_pos;
    status_end_pos_next   = status_end_pos;
    unsol_start_pos_next  = unsol_start_pos;
    unsol_end_pos_next    = unsol_end_pos;
    text_we               = 1'b0;
    if (step_en) begin
      if (msg_end) begin
        phase_next            = PH_START;
        byte_index_next       = '0;
        overflow_seen_next    = 1'b0;
        cmd_start_pos_next    = '0;
        cmd_end_pos_next      = '0;
        status_start_pos_next = '0;
        status_end_pos_next   = '0;
        unsol_start_pos_next  = '0;
        unsol_end_pos_next    = '0;
      end else begin
        unique case (phase)
          PH_ENTER_AT: begin
            if (char_in == CH_T_UP || char_in == CH_T_LO) begin
              phase_next         = PH_AT;
              cmd_start_pos_next = prev_pos;
            end else begin
              phase_next = PH_USER;
            end
          end
          PH_AT: begin
            if (char_in == CH_CR) phase_next = PH_ENTER_STATUS;
          end
          PH_ENTER_STATUS: begin
            if (char_in == CH_LF) begin
              phase_next            = PH_STATUS;
              status_start_pos_next = cur_pos_inc;
            end else if (char_in != CH_CR) begin
              phase_next = PH_AT;
            end
          end
          PH_STATUS, PH_SEND: begin
            if (char_in == CH_CR) begin
              phase_next          = (phase == PH_STATUS) ? PH_EXIT_STATUS : PH_EXIT_SEND;
              status_end_pos_next = cur_pos;
            end else begin
              text_we = cap_ok;
            end
          end
          PH_EXIT_STATUS: begin
            if (char_in == CH_LF && status_ok) begin
              phase_next       = PH_START;
              cmd_end_pos_next = cur_pos_inc;
            end else begin
              phase_next            = PH_AT;
              status_start_pos_next = '0;
              status_end_pos_next   = '0;
            end
          end
          PH_USER: begin
            if (char_in == CH_CR) phase_next = PH_ENTER_SEND;
          end
          PH_ENTER_SEND: begin
            if (char_in == CH_LF) begin
              phase_next            = PH_SEND;
              status_start_pos_next = cur_pos_inc;
            end else begin
              phase_next = PH_USER;
            end
          end
          PH_EXIT_SEND: begin
            // a failed send status keeps its offsets
            if (char_in == CH_LF && status_ok) begin
              phase_next       = PH_START;
              cmd_end_pos_next = cur_pos_inc;
            end else begin
              phase_next = PH_USER;
            end
          end
          PH_ENTER_URC: begin
            if (char_in == CH_LF) begin
              phase_next           = PH_URC;
              unsol_start_pos_next = prev_pos;
            end else begin
              phase_next = PH_USER;
            end
          end
          PH_URC: begin
            if (char_in == CH_CR) phase_next = PH_EXIT_URC;
          end
          PH_EXIT_URC: begin
            if (char_in == CH_LF) begin
              phase_next         = PH_START;
              unsol_end_pos_next = cur_pos_inc;
            end else begin
              phase_next = PH_URC;
            end
          end
          default: begin
            if (char_in == CH_A_UP || char_in == CH_A_LO) begin
              phase_next = PH_ENTER_AT;
            end else if (char_in == CH_CR) begin
              phase_next = PH_ENTER_URC;
            end else begin
              phase_next         = PH_USER;
              cmd_start_pos_next = cur_pos;
            end
          end
        endcase
        // saturate the index at its last value
        if (byte_index < IDX_LAST) begin
          byte_index_next = byte_index + IDX_W'(1);
        end else begin
          overflow_seen_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_START;
      byte_index       <= '0;
      overflow_seen    <= 1'b0;
      cmd_start_pos    <= '0;
      cmd_end_pos      <= '0;
      status_start_pos <= '0;
      status_end_pos   <= '0;
      unsol_start_pos  <= '0;
      unsol_end_pos    <= '0;
    end else begin
      phase            <= phase_next;
      byte_index       <= byte_index_next;
      overflow_seen    <= overflow_seen_next;
      cmd_start_pos    <= cmd_start_pos_next;
      cmd_end_pos      <= cmd_end_pos_next;
      status_start_pos <= status_start_pos_next;
      status_end_pos   <= status_end_pos_next;
      unsol_start_pos  <= unsol_start_pos_next;
      unsol_end_pos    <= unsol_end_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (text_we) begin
      status_text[text_addr] <= char_in;
    end
  end

  assign res_valid = step_en && msg_end;

  always_comb begin
    res.cmd_present    = (cmd_start_pos < cmd_end_fin);
    res.cmd_begin      = POS_OUT_W'(cmd_start_pos);
    res.cmd_finish     = POS_OUT_W'(cmd_end_fin);
    res.unsol_present  = (unsol_start_pos < unsol_end_pos);
    res.unsol_begin    = POS_OUT_W'(unsol_start_pos);
    res.unsol_finish   = POS_OUT_W'(unsol_end_pos);
    res.status_code    = status_code;
    res.index_overflow = overflow_seen;
  end

  a_overflow_saturated: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> byte_index == IDX_LAST)
    else $error("overflow flag set with index below its limit");

  a_status_start_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_STATUS || phase == PH_SEND) |-> status_start_pos != '0)
    else $error("status phase entered without a start offset");

endmodule

[rtl/core/atrsp_out_reg.sv]
module atrsp_out_reg import atrsp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_data,
  output logic    free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic full;

  assign free      = !full || out_ready;
  assign out_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (out_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result word overwritten while waiting");

endmodule

[rtl/core/at_response_stream_parser.sv]
// AT response stream parser.
// Input channel in_valid/in_ready carries one received character per word
// on char_byte; a zero byte ends the message. Output channel
// out_valid/out_ready carries one result word per message: command and
// unsolicited offsets with presence flags, the status code of the last
// recorded status line and the index overflow flag. Nonzero bytes give no
// output word.
// Throughput: one byte per cycle while no zero byte waits for the result
// slot. A byte is held in the input register and then updates the phase
// machine and offsets; the result of a zero byte is loaded into the output
// register as that byte leaves the input register, which raises out_valid.
// Keyword matching against the captured status text is done in the same
// cycle as the state update.
// When the receiver stalls, nonzero bytes keep flowing through the parser;
// a zero byte waits in the input register until the output word is taken.
// Reset clears the phase machine, the byte index, the offsets and both
// valid flags; the captured status text is not cleared.
module at_response_stream_parser import atrsp_pkg::*; #(
  parameter int MAX_LEN      = 1024,
  parameter int STATUS_CHARS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           char_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 cmd_present,
  output logic [POS_OUT_W-1:0] cmd_begin,
  output logic [POS_OUT_W-1:0] cmd_finish,
  output logic                 unsol_present,
  output logic [POS_OUT_W-1:0] unsol_begin,
  output logic [POS_OUT_W-1:0] unsol_finish,
  output logic [CODE_W-1:0]    status_code,
  output logic                 index_overflow
);

  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_fire, in_fire, slot_free, res_valid;
  result_t    res, out_data;

  // a zero byte advances only into a free result slot
  assign s1_fire  = s1_valid && ((s1_char != CH_NUL) || slot_free);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char <= char_byte;
    end
  end

  atrsp_parser #(
    .MAX_LEN      (MAX_LEN),
    .STATUS_CHARS (STATUS_CHARS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step_en   (s1_fire),
    .char_in   (s1_char),
    .res_valid (res_valid),
    .res       (res)
  );

  atrsp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .load_data (res),
    .free      (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign cmd_present    = out_data.cmd_present;
  assign cmd_begin      = out_data.cmd_begin;
  assign cmd_finish     = out_data.cmd_finish;
  assign unsol_present  = out_data.unsol_present;
  assign unsol_begin    = out_data.unsol_begin;
  assign unsol_finish   = out_data.unsol_finish;
  assign status_code    = out_data.status_code;
  assign index_overflow = out_data.index_overflow;

  a_ready_low_only_when_held: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && s1_char == CH_NUL)
    else $error("input stalled without a waiting zero byte");

  a_zero_byte_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_char))
    else $error("waiting zero byte lost");

endmodule
